// File: design/ebsab_pkg.sv
// Shared types, widths and codes for the edge bucket scatter / adjacency build block.
// No dependencies; ebsab_rmw_mem and the top level refer to this package by scoped names.

package ebsab_pkg;

	// default sizes handed to the top level
	localparam int BUCKETS_DEF   = 128;
	localparam int NODE_BITS_DEF = 20;
	localparam int LINK_BITS_DEF = 21;

	// fixed field widths of the ports
	localparam int REQ_W        = 2;
	localparam int EDGE_W       = 64;
	localparam int HALF_W       = 32;
	localparam int OFS_W        = 32;
	localparam int BIDX_W       = 7;
	localparam int FIRST_LINK_W = 21;
	localparam int LINK_OUT_W   = 21;
	localparam int TARGET_W     = 20;
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	// each scattered edge occupies one 8-byte slot
	localparam logic [OFS_W-1:0] OFS_STEP = 32'd8;

	// request codes on req_type
	typedef enum logic [REQ_W-1:0] {
		REQ_START  = 2'd0,
		REQ_EDGE   = 2'd1,
		REQ_FINISH = 2'd2
	} req_t;

	// record_kind codes
	typedef enum logic {
		REC_EDGE   = 1'b0,
		REC_HEADER = 1'b1
	} rec_kind_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FIRST_LINK  = 2'd0,
		CFG_DEST_BASE   = 2'd1,
		CFG_DEST_STRIDE = 2'd2
	} cfg_idx_t;

	// sequencer states
	typedef enum logic [1:0] {
		ST_CLR_HEAD,
		ST_CLR_BKT,
		ST_RUN,
		ST_FILL
	} state_t;

	// memory port controls
	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} mem_ctl_t;

endpackage

// File: design/ebsab_rmw_mem.sv
// Synchronous single-write, single-read table with registered read data and
// write-to-read forwarding for read-modify-write use. Depends on ebsab_pkg.

module ebsab_rmw_mem #(
	parameter int ADDR_W = 8,
	parameter int DATA_W = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ebsab_pkg::mem_ctl_t   ctl,
	input  logic [ADDR_W-1:0]     rd_addr,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic [DATA_W-1:0]     wr_data,
	output logic [DATA_W-1:0]     cur_data
);

	localparam longint unsigned DEPTH = 64'd1 << ADDR_W;

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [DATA_W-1:0] fwd_data_q;
	logic              fwd_q;

	// storage: write port and registered read port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// catch a write that lands on the entry being read in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (ctl.rd_en) begin
			fwd_q <= ctl.wr_en && (wr_addr == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			fwd_data_q <= wr_data;
		end
	end

	// pick the freshest copy
	assign cur_data = fwd_q ? fwd_data_q : rd_data_q;

endmodule

// File: design/ebsab_bkt_map.sv
// Destination bucket selection: high node modulo the bucket count, one register deep.
// Uses a mask for power-of-two counts, a reciprocal multiply otherwise. No package use.

module ebsab_bkt_map #(
	parameter int BUCKETS   = 128,
	parameter int NODE_BITS = 20
) (
	input  logic                        clk,
	input  logic                        load,
	input  logic [NODE_BITS-1:0]        node,
	output logic [$clog2(BUCKETS)-1:0]  bucket
);

	localparam int BKT_W = $clog2(BUCKETS);

	generate
		if ((BUCKETS & (BUCKETS - 1)) == 0) begin : g_pow2
			logic [BKT_W-1:0] bkt_s1;

			// keep the low bits
			always_ff @(posedge clk) begin
				if (load) begin
					bkt_s1 <= BKT_W'(node);
				end
			end

			assign bucket = bkt_s1;
		end else begin : g_recip
			localparam int SHIFT  = NODE_BITS + BKT_W;
			localparam int PROD_W = 2 * NODE_BITS + 1;
			localparam logic [63:0] RECIP =
				((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);

			logic [PROD_W-1:0]    prod_s1;
			logic [NODE_BITS-1:0] node_s1;
			logic [NODE_BITS-1:0] quot;
			logic [NODE_BITS-1:0] rem;

			// quotient estimate by reciprocal, exact over the node range
			always_ff @(posedge clk) begin
				if (load) begin
					node_s1 <= node;
					prod_s1 <= PROD_W'(node) * PROD_W'(RECIP[NODE_BITS:0]);
				end
			end

			assign quot   = NODE_BITS'(prod_s1 >> SHIFT);
			assign rem    = node_s1 - NODE_BITS'(quot * NODE_BITS'(BUCKETS));
			assign bucket = BKT_W'(rem);
		end
	endgenerate

endmodule

// File: design/edge_bucket_scatter_adjacency_build_top.sv
// Edge bucket scatter with adjacency list build: top level, sequencer and pipeline.
// Depends on ebsab_pkg, ebsab_bkt_map and ebsab_rmw_mem.
// A result word is registered in stage 1, in stage 2 and in the output register before it is presented.
// Throughput: one edge or finish request per cycle while out_stall is low, set by the single
// read-modify-write pass through the bucket and head tables; a start request refills every
// bucket pointer, and later requests wait until the refill is done. After reset the head and bucket
// tables are swept to zero, with no request taken (config accepted).

module edge_bucket_scatter_adjacency_build_top #(
	parameter int BUCKETS   = ebsab_pkg::BUCKETS_DEF,
	parameter int NODE_BITS = ebsab_pkg::NODE_BITS_DEF,
	parameter int LINK_BITS = ebsab_pkg::LINK_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// configuration
	input  logic                               cfg_wr_en,
	input  logic [ebsab_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ebsab_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
	// request channel
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ebsab_pkg::REQ_W-1:0]        req_type,
	input  logic [ebsab_pkg::EDGE_W-1:0]       raw_edge,
	// result channel
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               record_kind,
	output logic [ebsab_pkg::BIDX_W-1:0]       bucket_index,
	output logic [ebsab_pkg::OFS_W-1:0]        write_offset,
	output logic [ebsab_pkg::EDGE_W-1:0]       masked_edge,
	output logic [ebsab_pkg::LINK_OUT_W-1:0]   link_index,
	output logic [ebsab_pkg::LINK_OUT_W-1:0]   link_next,
	output logic [ebsab_pkg::TARGET_W-1:0]     link_target
);

	localparam int BKT_W = $clog2(BUCKETS);
	localparam logic [BKT_W-1:0] BKT_LAST = BKT_W'(BUCKETS - 1);

	// configuration registers
	logic [ebsab_pkg::FIRST_LINK_W-1:0] first_link_q;
	logic [ebsab_pkg::OFS_W-1:0]        dest_base_q;
	logic [ebsab_pkg::OFS_W-1:0]        dest_stride_q;

	// sequencer
	ebsab_pkg::state_t state_q, state_d;
	logic [NODE_BITS-1:0]        head_cnt_q;
	logic [BKT_W-1:0]            bkt_cnt_q;
	logic [ebsab_pkg::OFS_W-1:0] acc_q;
	logic                        bkt_last;
	logic                        clearing;

	// link counter
	logic [LINK_BITS-1:0] next_link_q;

	// request decode
	logic                 in_acc;
	logic [NODE_BITS-1:0] in_lo;
	logic [NODE_BITS-1:0] in_hi;

	// stage 1: bucket selection
	logic                 s1_v_q;
	ebsab_pkg::req_t      s1_kind_q;
	logic [NODE_BITS-1:0] s1_lo_q;
	logic [NODE_BITS-1:0] s1_hi_q;
	logic [LINK_BITS-1:0] s1_link_q;
	logic [BKT_W-1:0]     s1_bkt;
	logic                 s1_adv;

	// stage 2: table read data, write back, result
	logic                 s2_v_q;
	ebsab_pkg::req_t      s2_kind_q;
	logic [NODE_BITS-1:0] s2_lo_q;
	logic [NODE_BITS-1:0] s2_hi_q;
	logic [LINK_BITS-1:0] s2_link_q;
	logic [BKT_W-1:0]     s2_bkt_q;
	logic                 s2_res;
	logic                 s2_adv;
	logic                 s2_edge_go;

	// table ports
	ebsab_pkg::mem_ctl_t         bkt_ctl, head_ctl;
	logic [BKT_W-1:0]            bkt_wr_addr;
	logic [ebsab_pkg::OFS_W-1:0] bkt_wr_data;
	logic [ebsab_pkg::OFS_W-1:0] bkt_cur;
	logic [NODE_BITS-1:0]        head_wr_addr;
	logic [LINK_BITS-1:0]        head_wr_data;
	logic [LINK_BITS-1:0]        head_cur;

	// output register
	logic                                out_valid_q;
	logic                                record_kind_q;
	logic [ebsab_pkg::BIDX_W-1:0]        bucket_index_q;
	logic [ebsab_pkg::OFS_W-1:0]         write_offset_q;
	logic [ebsab_pkg::EDGE_W-1:0]        masked_edge_q;
	logic [ebsab_pkg::LINK_OUT_W-1:0]    link_index_q;
	logic [ebsab_pkg::LINK_OUT_W-1:0]    link_next_q;
	logic [ebsab_pkg::TARGET_W-1:0]      link_target_q;
	logic                                out_load;

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_link_q  <= '0;
			dest_base_q   <= '0;
			dest_stride_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				ebsab_pkg::CFG_FIRST_LINK:
					first_link_q <= cfg_wr_data[ebsab_pkg::FIRST_LINK_W-1:0];
				ebsab_pkg::CFG_DEST_BASE:   dest_base_q   <= cfg_wr_data;
				ebsab_pkg::CFG_DEST_STRIDE: dest_stride_q <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// handshake and stage advance
	assign clearing   = (state_q == ebsab_pkg::ST_CLR_HEAD) || (state_q == ebsab_pkg::ST_CLR_BKT);
	assign s2_res     = (s2_kind_q == ebsab_pkg::REQ_EDGE) || (s2_kind_q == ebsab_pkg::REQ_FINISH);
	assign s2_adv     = s2_v_q && (!s2_res || !out_valid_q || !out_stall);
	assign s2_edge_go = s2_adv && (s2_kind_q == ebsab_pkg::REQ_EDGE);
	assign s1_adv     = s1_v_q && (state_q == ebsab_pkg::ST_RUN)
		&& !(s2_v_q && (s2_kind_q == ebsab_pkg::REQ_START))
		&& (!s2_v_q || s2_adv);
	assign in_stall   = clearing || (s1_v_q && !s1_adv);
	assign in_acc     = in_valid && !in_stall;

	// cut both node halves
	assign in_lo = raw_edge[NODE_BITS-1:0];
	assign in_hi = raw_edge[ebsab_pkg::HALF_W +: NODE_BITS];

	// link counter advances in request order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_link_q <= '0;
		end else if (in_acc) begin
			case (ebsab_pkg::req_t'(req_type))
				ebsab_pkg::REQ_START: next_link_q <= LINK_BITS'(first_link_q) + LINK_BITS'(1);
				ebsab_pkg::REQ_EDGE:  next_link_q <= next_link_q + LINK_BITS'(1);
				default: ;
			endcase
		end
	end

	ebsab_bkt_map #(
		.BUCKETS   (BUCKETS),
		.NODE_BITS (NODE_BITS)
	) u_bkt_map (
		.clk    (clk),
		.load   (in_acc),
		.node   (in_hi),
		.bucket (s1_bkt)
	);

	// stage 1 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q <= 1'b0;
		end else if (in_acc) begin
			s1_v_q <= 1'b1;
		end else if (s1_adv) begin
			s1_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			s1_kind_q <= ebsab_pkg::req_t'(req_type);
			s1_lo_q   <= in_lo;
			s1_hi_q   <= in_hi;
			s1_link_q <= next_link_q;
		end
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v_q <= 1'b0;
		end else if (s1_adv) begin
			s2_v_q <= 1'b1;
		end else if (s2_adv) begin
			s2_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			s2_kind_q <= s1_kind_q;
			s2_lo_q   <= s1_lo_q;
			s2_hi_q   <= s1_hi_q;
			s2_link_q <= s1_link_q;
			s2_bkt_q  <= s1_bkt;
		end
	end

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ebsab_pkg::ST_CLR_HEAD;
		end else begin
			state_q <= state_d;
		end
	end

	assign bkt_last = (bkt_cnt_q == BKT_LAST);

	// next state and table port steering
	always_comb begin
		state_d       = state_q;
		bkt_ctl       = '0;
		head_ctl      = '0;
		bkt_ctl.rd_en = s1_adv;
		head_ctl.rd_en = s1_adv;
		bkt_wr_addr   = s2_bkt_q;
		bkt_wr_data   = bkt_cur + ebsab_pkg::OFS_STEP;
		head_wr_addr  = s2_lo_q;
		head_wr_data  = s2_link_q;
		case (state_q)
			ebsab_pkg::ST_CLR_HEAD: begin
				head_ctl.wr_en = 1'b1;
				head_wr_addr   = head_cnt_q;
				head_wr_data   = '0;
				if (&head_cnt_q) begin
					state_d = ebsab_pkg::ST_CLR_BKT;
				end
			end
			ebsab_pkg::ST_CLR_BKT: begin
				bkt_ctl.wr_en = 1'b1;
				bkt_wr_addr   = bkt_cnt_q;
				bkt_wr_data   = '0;
				if (bkt_last) begin
					state_d = ebsab_pkg::ST_RUN;
				end
			end
			ebsab_pkg::ST_FILL: begin
				bkt_ctl.wr_en = 1'b1;
				bkt_wr_addr   = bkt_cnt_q;
				bkt_wr_data   = acc_q;
				if (bkt_last) begin
					state_d = ebsab_pkg::ST_RUN;
				end
			end
			ebsab_pkg::ST_RUN: begin
				bkt_ctl.wr_en  = s2_edge_go;
				head_ctl.wr_en = s2_edge_go;
				if (s2_adv && (s2_kind_q == ebsab_pkg::REQ_START)) begin
					state_d = ebsab_pkg::ST_FILL;
				end
			end
			default: state_d = ebsab_pkg::ST_CLR_HEAD;
		endcase
	end

	// sweep counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_cnt_q <= '0;
			bkt_cnt_q  <= '0;
		end else begin
			if (state_q == ebsab_pkg::ST_CLR_HEAD) begin
				head_cnt_q <= head_cnt_q + NODE_BITS'(1);
			end
			if ((state_q == ebsab_pkg::ST_CLR_BKT) || (state_q == ebsab_pkg::ST_FILL)) begin
				bkt_cnt_q <= bkt_last ? '0 : bkt_cnt_q + BKT_W'(1);
			end
		end
	end

	// running bucket offset: base, then plus stride per bucket
	always_ff @(posedge clk) begin
		if ((state_q == ebsab_pkg::ST_RUN) && (state_d == ebsab_pkg::ST_FILL)) begin
			acc_q <= dest_base_q;
		end else if (state_q == ebsab_pkg::ST_FILL) begin
			acc_q <= acc_q + dest_stride_q;
		end
	end

	ebsab_rmw_mem #(
		.ADDR_W (BKT_W),
		.DATA_W (ebsab_pkg::OFS_W)
	) u_bkt_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (bkt_ctl),
		.rd_addr  (s1_bkt),
		.wr_addr  (bkt_wr_addr),
		.wr_data  (bkt_wr_data),
		.cur_data (bkt_cur)
	);

	ebsab_rmw_mem #(
		.ADDR_W (NODE_BITS),
		.DATA_W (LINK_BITS)
	) u_head_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (head_ctl),
		.rd_addr  (s1_lo_q),
		.wr_addr  (head_wr_addr),
		.wr_data  (head_wr_data),
		.cur_data (head_cur)
	);

	// output word register
	assign out_load = s2_adv && s2_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (s2_kind_q == ebsab_pkg::REQ_EDGE) begin
				record_kind_q  <= ebsab_pkg::REC_EDGE;
				bucket_index_q <= ebsab_pkg::BIDX_W'(s2_bkt_q);
				write_offset_q <= bkt_cur;
				masked_edge_q  <= {ebsab_pkg::HALF_W'(s2_hi_q), ebsab_pkg::HALF_W'(s2_lo_q)};
				link_index_q   <= ebsab_pkg::LINK_OUT_W'(s2_link_q);
				link_next_q    <= ebsab_pkg::LINK_OUT_W'(head_cur);
				link_target_q  <= ebsab_pkg::TARGET_W'(s2_hi_q ^ NODE_BITS'(1));
			end else begin
				record_kind_q  <= ebsab_pkg::REC_HEADER;
				bucket_index_q <= '0;
				write_offset_q <= '0;
				masked_edge_q  <= '0;
				link_index_q   <= ebsab_pkg::LINK_OUT_W'(first_link_q);
				link_next_q    <= ebsab_pkg::LINK_OUT_W'(s2_link_q);
				link_target_q  <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign record_kind  = record_kind_q;
	assign bucket_index = bucket_index_q;
	assign write_offset = write_offset_q;
	assign masked_edge  = masked_edge_q;
	assign link_index   = link_index_q;
	assign link_next    = link_next_q;
	assign link_target  = link_target_q;

	// no request enters while the tables are being cleared
	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> in_stall)
		else $error("request accepted during table clear");

	// the refill only runs with nothing left in the table stage
	a_fill_stage_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ebsab_pkg::ST_FILL) |-> !s2_v_q)
		else $error("table stage busy during bucket refill");

	// a refill is entered only by a start request leaving the table stage
	a_fill_entry: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ebsab_pkg::ST_FILL) && ($past(state_q) == ebsab_pkg::ST_RUN))
		|-> $past(s2_adv && (s2_kind_q == ebsab_pkg::REQ_START)))
		else $error("bucket refill started without a start request");

	// a result blocked by a full output register stays in the table stage
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(s2_v_q && s2_res && out_valid_q && out_stall) |=> s2_v_q)
		else $error("result lost while output stalled");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Testbench for edge_bucket_scatter_adjacency_build_top: a directed table, then random rounds.
// Depends on ebsab_pkg and the top level; the bucket and adjacency state is predicted here.

module testbench;

	localparam int BKT       = ebsab_pkg::BUCKETS_DEF;
	localparam int SETTLE    = ebsab_pkg::BUCKETS_DEF + 8;
	localparam int ROUNDS    = 8;
	localparam int ROUND_LEN = 120;
	localparam int LONG_HOLD = 60;
	localparam logic [ebsab_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

	// one result word, field by field
	typedef struct packed {
		ebsab_pkg::rec_kind_t                kind;
		logic [ebsab_pkg::BIDX_W-1:0]        bucket;
		logic [ebsab_pkg::OFS_W-1:0]         offset;
		logic [ebsab_pkg::EDGE_W-1:0]        edge_word;
		logic [ebsab_pkg::LINK_OUT_W-1:0]    lidx;
		logic [ebsab_pkg::LINK_OUT_W-1:0]    lnext;
		logic [ebsab_pkg::TARGET_W-1:0]      target;
	} record_t;

	// one row of the directed table: a register write or a request
	typedef struct {
		bit                                is_cfg;
		ebsab_pkg::cfg_idx_t               reg_sel;
		logic [31:0]                       reg_val;
		logic [ebsab_pkg::REQ_W-1:0]       req;
		logic [ebsab_pkg::EDGE_W-1:0]      word;
		bit                                typed;
		record_t                           want;
	} plan_row_t;

	logic                                clk;
	logic                                arst_n;
	logic                                cfg_wr_en;
	logic [ebsab_pkg::CFG_IDX_W-1:0]     cfg_index;
	logic [ebsab_pkg::CFG_DATA_W-1:0]    cfg_wr_data;
	logic                                in_valid;
	logic                                in_stall;
	logic [ebsab_pkg::REQ_W-1:0]         req_type;
	logic [ebsab_pkg::EDGE_W-1:0]        raw_edge;
	logic                                out_valid;
	logic                                out_stall;
	logic                                record_kind;
	logic [ebsab_pkg::BIDX_W-1:0]        bucket_index;
	logic [ebsab_pkg::OFS_W-1:0]         write_offset;
	logic [ebsab_pkg::EDGE_W-1:0]        masked_edge;
	logic [ebsab_pkg::LINK_OUT_W-1:0]    link_index;
	logic [ebsab_pkg::LINK_OUT_W-1:0]    link_next;
	logic [ebsab_pkg::TARGET_W-1:0]      link_target;

	// shadow of the block's registers and tables
	logic [ebsab_pkg::FIRST_LINK_W-1:0]  first_link_reg;
	logic [31:0]                         dest_base_reg;
	logic [31:0]                         dest_stride_reg;
	logic [31:0]                         bucket_ofs [BKT];
	logic [ebsab_pkg::LINK_OUT_W-1:0]    node_head [logic [19:0]];
	logic [ebsab_pkg::LINK_OUT_W-1:0]    link_count;

	record_t                  pending_records [$];
	plan_row_t                plan [$];
	int                       fail_count = 0;
	int                       long_hold = 0;
	bit                       in_calm = 1'b0;
	bit                       out_calm = 1'b0;

	edge_bucket_scatter_adjacency_build_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wr_data  (cfg_wr_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.req_type     (req_type),
		.raw_edge     (raw_edge),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.record_kind  (record_kind),
		.bucket_index (bucket_index),
		.write_offset (write_offset),
		.masked_edge  (masked_edge),
		.link_index   (link_index),
		.link_next    (link_next),
		.link_target  (link_target)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#50_000_000;
		$display("testbench NOT OK");
		$finish;
	end

	// apply one request to the shadow state; return 1 with the record it should produce
	function automatic bit advance_scatter(input logic [ebsab_pkg::REQ_W-1:0] req,
			input logic [ebsab_pkg::EDGE_W-1:0] word, output record_t rec);
		logic [19:0] lo_node;
		logic [19:0] hi_node;
		logic [31:0] ofs;
		int          b;
		rec = '0;
		lo_node = word[19:0];
		hi_node = word[51:32];
		case (req)
			ebsab_pkg::REQ_START: begin
				ofs = dest_base_reg;
				for (int i = 0; i < BKT; i++) begin
					bucket_ofs[i] = ofs;
					ofs = ofs + dest_stride_reg;
				end
				link_count = first_link_reg + 1'b1;
				return 1'b0;
			end
			ebsab_pkg::REQ_EDGE: begin
				b = hi_node % BKT;
				rec.kind = ebsab_pkg::REC_EDGE;
				rec.bucket = ebsab_pkg::BIDX_W'(b);
				rec.offset = bucket_ofs[b];
				rec.edge_word = {12'h0, hi_node, 12'h0, lo_node};
				rec.lidx = link_count;
				rec.lnext = node_head.exists(lo_node) ? node_head[lo_node] : '0;
				rec.target = hi_node ^ 20'h1;
				bucket_ofs[b] = bucket_ofs[b] + ebsab_pkg::OFS_STEP;
				node_head[lo_node] = link_count;
				link_count = link_count + 1'b1;
				return 1'b1;
			end
			ebsab_pkg::REQ_FINISH: begin
				rec.kind = ebsab_pkg::REC_HEADER;
				rec.lidx = first_link_reg;
				rec.lnext = link_count;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	function automatic record_t rec_of(input ebsab_pkg::rec_kind_t kind, input logic [6:0] b,
			input logic [31:0] ofs, input logic [63:0] word, input logic [20:0] li,
			input logic [20:0] ln, input logic [19:0] t);
		rec_of = {kind, b, ofs, word, li, ln, t};
	endfunction

	task automatic plan_cfg(input ebsab_pkg::cfg_idx_t sel, input logic [31:0] val);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.reg_sel = sel;
		row.reg_val = val;
		row.req = '0;
		row.word = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan.push_back(row);
	endtask

	task automatic plan_req(input logic [ebsab_pkg::REQ_W-1:0] req,
			input logic [ebsab_pkg::EDGE_W-1:0] word, input bit typed, input record_t want);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.reg_sel = ebsab_pkg::CFG_FIRST_LINK;
		row.reg_val = '0;
		row.req = req;
		row.word = word;
		row.typed = typed;
		row.want = want;
		plan.push_back(row);
	endtask

	function automatic logic [31:0] draw_reg(input logic [31:0] top);
		case ($urandom_range(0, 3))
			0: return '0;
			1: return top;
			default: return $urandom & top;
		endcase
	endfunction

	// random edge word; low nodes crowd onto a few ids so adjacency lists grow long
	function automatic logic [ebsab_pkg::EDGE_W-1:0] random_word();
		logic [ebsab_pkg::EDGE_W-1:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 7))
			0, 1, 2, 3: w[19:0] = 20'($urandom_range(0, 15));
			4: w[19:0] = $urandom_range(0, 1) ? '1 : '0;
			default: ;
		endcase
		if ($urandom_range(0, 7) == 0)
			w[51:32] = $urandom_range(0, 1) ? '1 : '0;
		return w;
	endfunction

	// offer one request word, hold it until taken, then record what it should produce
	task automatic offer(input logic [ebsab_pkg::REQ_W-1:0] req,
			input logic [ebsab_pkg::EDGE_W-1:0] word, input bit typed, input record_t want);
		int      gap;
		record_t rec;
		gap = in_calm ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		raw_edge <= word;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (advance_scatter(req, word, rec))
			pending_records.push_back(typed ? want : rec);
	endtask

	// stop offering and wait until every expected word has arrived
	task automatic wait_drained(input int extra);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_records.size() > 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_reg(input ebsab_pkg::cfg_idx_t sel, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= sel;
		cfg_wr_data <= val;
		@(posedge clk);
		case (sel)
			ebsab_pkg::CFG_FIRST_LINK:  first_link_reg = val[ebsab_pkg::FIRST_LINK_W-1:0];
			ebsab_pkg::CFG_DEST_BASE:   dest_base_reg = val;
			ebsab_pkg::CFG_DEST_STRIDE: dest_stride_reg = val;
			default: ;
		endcase
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	function automatic void check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
			fail_count++;
		end
	endfunction

	// compare one taken result word with the oldest expectation
	task automatic take_record();
		record_t want;
		if (pending_records.size() == 0) begin
			$display("%0t: result word with none expected, actual kind %h link_index %h",
				$time, record_kind, link_index);
			fail_count++;
		end else begin
			want = pending_records.pop_front();
			check_field("record_kind", 64'(want.kind), 64'(record_kind));
			check_field("bucket_index", 64'(want.bucket), 64'(bucket_index));
			check_field("write_offset", 64'(want.offset), 64'(write_offset));
			check_field("masked_edge", want.edge_word, masked_edge);
			check_field("link_index", 64'(want.lidx), 64'(link_index));
			check_field("link_next", 64'(want.lnext), 64'(link_next));
			check_field("link_target", 64'(want.target), 64'(link_target));
		end
	endtask

	// result side: stall a random number of cycles before each word, or a long hold on request
	initial begin : drain
		int hold;
		out_stall <= 1'b1;
		@(posedge clk);
		forever begin
			if (long_hold > 0) begin
				hold = long_hold;
				long_hold = 0;
			end else begin
				hold = out_calm ? 0 : $urandom_range(0, 10);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			take_record();
		end
	end

	// request side: reset, directed table, random rounds, drain
	initial begin : stimulus
		logic [ebsab_pkg::REQ_W-1:0] req;
		int                          pick;
		int                          sent;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		req_type <= ebsab_pkg::REQ_START;
		raw_edge <= '0;
		cfg_wr_en <= 1'b0;
		cfg_index <= ebsab_pkg::CFG_FIRST_LINK;
		cfg_wr_data <= '0;
		first_link_reg = '0;
		dest_base_reg = '0;
		dest_stride_reg = '0;
		link_count = '0;
		foreach (bucket_ofs[i]) bucket_ofs[i] = '0;

		// defaults after reset: header, edges before any start, ignored code
		plan_req(ebsab_pkg::REQ_FINISH, 64'h0, 1'b1,
			rec_of(ebsab_pkg::REC_HEADER, 0, 0, 0, 0, 0, 0));
		plan_req(ebsab_pkg::REQ_EDGE, 64'h0, 1'b1,
			rec_of(ebsab_pkg::REC_EDGE, 0, 0, 0, 0, 0, 20'h1));
		plan_req(ebsab_pkg::REQ_EDGE, '1, 1'b1, rec_of(ebsab_pkg::REC_EDGE, 7'h7f, 0,
			64'h000f_ffff_000f_ffff, 1, 0, 20'hffffe));
		plan_req(REQ_UNUSED, '1, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_FINISH, 64'h0, 1'b1,
			rec_of(ebsab_pkg::REC_HEADER, 0, 0, 0, 0, 2, 0));
		plan_req(ebsab_pkg::REQ_EDGE, 64'h0000_0000_000f_ffff, 1'b0, '0);
		// top extremes: link counter wraps at start, offsets wrap at 32 bits
		plan_cfg(ebsab_pkg::CFG_FIRST_LINK, 32'h001f_ffff);
		plan_cfg(ebsab_pkg::CFG_DEST_BASE, 32'hffff_fff8);
		plan_cfg(ebsab_pkg::CFG_DEST_STRIDE, 32'hffff_ffff);
		plan_req(ebsab_pkg::REQ_START, 64'h0, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_FINISH, 64'h0, 1'b1,
			rec_of(ebsab_pkg::REC_HEADER, 0, 0, 0, 21'h1f_ffff, 0, 0));
		plan_req(ebsab_pkg::REQ_EDGE, 64'h5, 1'b1,
			rec_of(ebsab_pkg::REC_EDGE, 0, 32'hffff_fff8, 64'h5, 0, 0, 1));
		plan_req(ebsab_pkg::REQ_EDGE, 64'hfff0_0000_fff0_0005, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_EDGE, 64'h0000_007f_0008_0000, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_EDGE, 64'h0000_0080_0000_0001, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_FINISH, 64'h0, 1'b0, '0);
		// bottom extremes: every bucket at one offset, heads kept across the start
		plan_cfg(ebsab_pkg::CFG_FIRST_LINK, 32'h0);
		plan_cfg(ebsab_pkg::CFG_DEST_BASE, 32'h0);
		plan_cfg(ebsab_pkg::CFG_DEST_STRIDE, 32'h0);
		plan_req(ebsab_pkg::REQ_START, '1, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_EDGE, 64'h0000_0003_0000_0005, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_EDGE, 64'ha5a5_5a5a_5a5a_a5a5, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_EDGE, 64'h0000_0003_0000_0005, 1'b0, '0);
		plan_req(ebsab_pkg::REQ_FINISH, 64'h0, 1'b0, '0);
		plan_req(REQ_UNUSED, 64'h0, 1'b0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// walk the directed table
		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				wait_drained(SETTLE);
				write_reg(plan[i].reg_sel, plan[i].reg_val);
			end else begin
				offer(plan[i].req, plan[i].word, plan[i].typed, plan[i].want);
			end
		end

		// random rounds: new settings, start, mostly edges, finish
		for (int r = 0; r < ROUNDS; r++) begin
			wait_drained(SETTLE);
			write_reg(ebsab_pkg::CFG_FIRST_LINK, draw_reg(32'h001f_ffff));
			write_reg(ebsab_pkg::CFG_DEST_BASE, draw_reg(32'hffff_ffff));
			write_reg(ebsab_pkg::CFG_DEST_STRIDE, draw_reg(32'hffff_ffff));
			in_calm = ($urandom_range(0, 3) == 0);
			out_calm = ($urandom_range(0, 3) == 0);
			offer(ebsab_pkg::REQ_START, random_word(), 1'b0, '0);
			sent = 0;
			while (sent < ROUND_LEN) begin
				// back up the block: long receiver hold while words keep coming
				if (r == 1 && sent == 20) begin
					long_hold = LONG_HOLD;
					in_calm = 1'b1;
				end
				if (r == 1 && sent == 70)
					in_calm = 1'b0;
				// let the pipeline run dry mid-round
				if (r == 3 && sent == 50)
					wait_drained(0);
				pick = $urandom_range(0, 99);
				if (pick < 88)
					req = ebsab_pkg::REQ_EDGE;
				else if (pick < 93)
					req = ebsab_pkg::REQ_FINISH;
				else if (pick < 97)
					req = ebsab_pkg::REQ_START;
				else
					req = REQ_UNUSED;
				offer(req, random_word(), 1'b0, '0);
				if (req != REQ_UNUSED)
					sent++;
			end
			offer(ebsab_pkg::REQ_FINISH, random_word(), 1'b0, '0);
		end

		wait_drained(SETTLE);
		if (fail_count == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
